/* rtl/cdc_pkg.sv */
// ----------------------------------------------------------------------------
// cdc_pkg
// Types and constants shared by the cassette deck control unit.
// ----------------------------------------------------------------------------
package cdc_pkg;

  localparam int unsigned TimerW = 19;

  localparam logic [TimerW-1:0] SearchHoldReset = 19'd350000;
  localparam logic [TimerW-1:0] EjectDelayReset = 19'd1000;

  // event codes
  typedef enum logic [3:0] {
    OpPortA  = 4'd0,
    OpPortC  = 4'd1,
    OpTapeBit = 4'd2,
    OpRemote = 4'd3,
    OpEnd    = 4'd4,
    OpTop    = 4'd5,
    OpTick   = 4'd6,
    OpPlay   = 4'd7,
    OpRecord = 4'd8,
    OpClose  = 4'd9
  } cdc_op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgOlderMode   = 2'd0,
    CfgSearchHold  = 2'd1,
    CfgEjectDelay  = 2'd2
  } cdc_cfg_idx_e;

  typedef enum logic [1:0] {
    DirNormal  = 2'd0,
    DirFastFwd = 2'd1,
    DirRewind  = 2'd2
  } cdc_dir_e;

  // status nibble holds port B bits 6..3
  localparam int unsigned StRemote = 0;
  localparam int unsigned StTape0  = 1;
  localparam int unsigned StTape1  = 2;
  localparam int unsigned StData   = 3;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] port_value;
    logic       level;
  } cdc_in_t;

  typedef struct packed {
    logic [6:0] port_b_bits;
    logic       motor_on;
    logic [1:0] tape_direction;
    logic       mic_out;
    logic       special_reset_pulse;
    logic       full_reset_pulse;
    logic       eject_pulse;
    logic       playing;
    logic       rewinding;
  } cdc_out_t;

  typedef struct packed {
    logic              older_mode;
    logic [TimerW-1:0] search_hold;
    logic [TimerW-1:0] eject_delay;
  } cdc_cfg_t;

  typedef struct packed {
    logic [7:0]        last_pa;
    logic [7:0]        last_pc;
    logic              play;
    logic              rec;
    logic              fwd_run;
    logic              now_rew;
    logic              search;
    logic [3:0]        status;
    logic              motor;
    cdc_dir_e          dir;
    logic              mic;
    logic              s_act;
    logic [TimerW-1:0] s_cnt;
    logic              e_act;
    logic [TimerW-1:0] e_cnt;
  } cdc_state_t;

  localparam cdc_state_t StateReset = '{
    last_pa:  8'hff,
    last_pc:  8'hff,
    play:     1'b0,
    rec:      1'b0,
    fwd_run:  1'b0,
    now_rew:  1'b0,
    search:   1'b0,
    status:   4'b0110,
    motor:    1'b0,
    dir:      DirNormal,
    mic:      1'b1,
    s_act:    1'b0,
    s_cnt:    '0,
    e_act:    1'b0,
    e_cnt:    '0
  };

endpackage

/* rtl/cdc_cfg.sv */
// ----------------------------------------------------------------------------
// cdc_cfg
// Configuration register file: older mode flag and the two timer periods.
// ----------------------------------------------------------------------------
module cdc_cfg
  import cdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [TimerW-1:0] cfg_data_i,
  output cdc_cfg_t          cfg_o
);

  cdc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgOlderMode:  cfg_d.older_mode  = cfg_data_i[0];
        CfgSearchHold: cfg_d.search_hold = cfg_data_i;
        CfgEjectDelay: cfg_d.eject_delay = cfg_data_i;
        default: ; // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.older_mode  <= 1'b0;
      cfg_q.search_hold <= SearchHoldReset;
      cfg_q.eject_delay <= EjectDelayReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/cdc_step.sv */
// ----------------------------------------------------------------------------
// cdc_step
// Next-state and result logic for one event word.
// ----------------------------------------------------------------------------
module cdc_step
  import cdc_pkg::*;
(
  input  cdc_state_t st_i,
  input  cdc_cfg_t   cfg_i,
  input  cdc_in_t    item_i,
  output cdc_state_t st_o,
  output cdc_out_t   res_o
);

  function automatic cdc_state_t go_ff(cdc_state_t s);
    cdc_state_t r;
    r = s;
    if (s.play) begin
      r.motor = 1'b1;
      r.dir   = DirFastFwd;
    end
    r.fwd_run = 1'b0;
    r.now_rew = 1'b0;
    return r;
  endfunction

  function automatic cdc_state_t go_rew(cdc_state_t s);
    cdc_state_t r;
    r = s;
    if (s.play) begin
      r.motor = 1'b1;
      r.dir   = DirRewind;
    end
    r.now_rew = s.play;
    r.fwd_run = 1'b0;
    return r;
  endfunction

  function automatic cdc_state_t go_fwd(cdc_state_t s);
    cdc_state_t r;
    r = s;
    if (s.play || s.rec) begin
      r.motor = 1'b1;
      r.dir   = DirNormal;
    end
    r.fwd_run = s.play || s.rec;
    r.now_rew = 1'b0;
    return r;
  endfunction

  function automatic cdc_state_t go_stop(cdc_state_t s);
    cdc_state_t r;
    r = s;
    if (s.play || s.rec) r.motor = 1'b0;
    r.fwd_run        = 1'b0;
    r.now_rew        = 1'b0;
    r.status[StData] = 1'b0;
    return r;
  endfunction

  logic [7:0] pa, pc, d;
  logic       lv, sp, fr, ej;
  cdc_state_t s;

  always_comb begin
    s  = st_i;
    pa = st_i.last_pa;
    pc = st_i.last_pc;
    d  = item_i.port_value;
    lv = item_i.level;
    sp = 1'b0;
    fr = 1'b0;
    ej = 1'b0;
    unique case (item_i.op)
      OpPortA: begin
        if (!cfg_i.older_mode) begin
          // newer deck: falling edges, bit 7 low selects search
          if (pa[0] && !d[0]) begin
            s        = go_rew(s);
            s.search = !pa[7];
          end
          if (pa[1] && !d[1]) begin
            s        = go_ff(s);
            s.search = !pa[7];
          end
          if (pa[2] && !d[2]) begin
            s        = go_fwd(s);
            s.search = 1'b0;
          end
          if (pa[3] && !d[3]) begin
            s        = go_stop(s);
            s.s_act  = 1'b0;
            s.s_cnt  = '0;
            s.search = 1'b0;
          end
        end else begin
          // older deck: rising edges, bit 1 picks wind direction
          if (!pa[0] && d[0]) begin
            if (d[1]) s = go_ff(s);
            else      s = go_rew(s);
          end
          if (!pa[2] && d[2]) s = go_fwd(s);
          if (!pa[3] && d[3]) s = go_stop(s);
        end
        s.last_pa = d;
      end
      OpPortC: begin
        sp = !pc[1] && d[1];
        fr = !pc[3] && d[3];
        if (pc[4] && !d[4]) begin
          s.e_act = 1'b1;
          s.e_cnt = cfg_i.eject_delay;
        end else if (!pc[4] && d[4]) begin
          s.e_act = 1'b0;
          s.e_cnt = '0;
        end
        s.mic     = d[7];
        s.last_pc = d;
      end
      OpTapeBit: begin
        if (s.search) begin
          if (lv && !s.s_act) begin
            s.s_act          = 1'b1;
            s.s_cnt          = cfg_i.search_hold;
            s.status[StData] = 1'b1;
          end
        end else if (s.fwd_run) begin
          s.status[StData] = lv;
        end
      end
      OpRemote: s.status[StRemote] = !lv;
      OpEnd: begin
        if (lv && s.fwd_run) begin
          if (!cfg_i.older_mode && !pa[5]) s = go_rew(s);
          s.fwd_run = 1'b0;
        end
      end
      OpTop: begin
        if (lv && s.now_rew) begin
          if (!cfg_i.older_mode && !pa[6]) s = go_fwd(s);
          s.now_rew = 1'b0;
        end
      end
      OpTick: begin
        if (s.s_act) begin
          if (s.s_cnt <= TimerW'(1)) begin
            s.s_act          = 1'b0;
            s.s_cnt          = '0;
            s.status[StData] = 1'b0;
          end else begin
            s.s_cnt = s.s_cnt - TimerW'(1);
          end
        end
        if (s.e_act) begin
          if (s.e_cnt <= TimerW'(1)) begin
            s.e_act = 1'b0;
            s.e_cnt = '0;
            ej      = 1'b1;
          end else begin
            s.e_cnt = s.e_cnt - TimerW'(1);
          end
        end
      end
      OpPlay: begin
        s.play            = lv;
        s.rec             = 1'b0;
        s.status[StTape0] = 1'b1;
        s.status[StTape1] = !lv;
      end
      OpRecord: begin
        s.play            = 1'b0;
        s.rec             = lv;
        s.status[StTape0] = !lv;
        s.status[StTape1] = !lv;
      end
      OpClose: begin
        s.play            = 1'b0;
        s.rec             = 1'b0;
        s.fwd_run         = 1'b0;
        s.now_rew         = 1'b0;
        s.status[StData]  = 1'b0;
        s.status[StTape0] = 1'b1;
        s.status[StTape1] = 1'b1;
        s.s_act           = 1'b0;
        s.s_cnt           = '0;
      end
      default: ; // unused codes leave state alone
    endcase
  end

  assign st_o = s;

  always_comb begin
    res_o.port_b_bits         = {s.status, 3'b000};
    res_o.motor_on            = s.motor;
    res_o.tape_direction      = s.dir;
    res_o.mic_out             = s.mic;
    res_o.special_reset_pulse = sp;
    res_o.full_reset_pulse    = fr;
    res_o.eject_pulse         = ej;
    res_o.playing             = s.fwd_run;
    res_o.rewinding           = s.now_rew;
  end

endmodule

/* rtl/cassette_deck_control_unit.sv */
// ----------------------------------------------------------------------------
// cassette_deck_control_unit
// Cassette deck controller behind a parallel port, one event word in and one
// status word out.
// ----------------------------------------------------------------------------
// Each accepted input word is one event (port A or C write, tape bit, remote,
// tape end/top, timer tick, play, record, close). Its effect on the deck
// state and the resulting status word are worked out in a single cycle; the
// status word appears in the output register on the next cycle, so latency is
// one cycle and a new word may be taken every cycle. Input stall rises only
// when the output register holds a word that the sink is stalling. The two
// timers (search hold, eject delay) count timer tick events, not clocks.
// Configuration writes are always ready and take effect on the next cycle;
// write them only while the unit is idle.
// ----------------------------------------------------------------------------
module cassette_deck_control_unit
  import cdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // event input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cdc_in_t           in_data_i,
  // status output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cdc_out_t          out_data_o,
  // configuration write port
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [TimerW-1:0] cfg_data_i
);

  cdc_cfg_t   cfg;
  cdc_state_t state_q, state_d;
  cdc_out_t   res, out_q;
  logic       out_valid_q;
  logic       in_accept;

  assign cfg_ready_o = 1'b1;

  cdc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cdc_step u_step (
    .st_i   (state_q),
    .cfg_i  (cfg),
    .item_i (in_data_i),
    .st_o   (state_d),
    .res_o  (res)
  );

  // output register frees up in the same cycle it is taken
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/cdc_checker.sv */
// ----------------------------------------------------------------------------
// cdc_checker
// Port-level checks for the cassette deck control unit, bound to the top.
// ----------------------------------------------------------------------------
module cdc_checker
  import cdc_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input cdc_out_t out_data_o
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  // accepted word shows up as a valid output in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted word gave no result next cycle");

  // input only stalls behind a full output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  a_low_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.port_b_bits[2:0] == 3'b000 &&
                    out_data_o.tape_direction != 2'd3)
    else $error("port B low bits or direction code out of range");

  a_play_rew: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.playing && out_data_o.rewinding))
    else $error("playing and rewinding both set");

endmodule

bind cassette_deck_control_unit cdc_checker u_cdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
